// ===== hdl/bcdec_pkg.sv =====
// Shared types, codes and arithmetic helpers of the BC1/BC2/BC3 block decoder.
// No dependencies; every other file but bcdec_if imports this package.
`timescale 1ns / 1ps

package bcdec_pkg;

    localparam int MAX_IMAGE_SIDE = 16384;
    localparam int SIDE_W         = 15;
    localparam int QUEUE_DEPTH    = 2;
    localparam int TEXELS         = 16;

    typedef enum logic [1:0] {
        FMT_BC1 = 2'd0,
        FMT_BC2 = 2'd1,
        FMT_BC3 = 2'd2
    } t_fmt;

    typedef enum logic [1:0] {
        CFG_FORMAT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_fmt              fmt;
        logic [SIDE_W-1:0] width;
        logic [SIDE_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic [11:0]           bx;
        logic [11:0]           by;
        t_fmt                  fmt;
        logic                  three_mode;
        logic [3:0][2:0][7:0]  cpal;
        logic [7:0][7:0]       apal;
        logic [31:0]           cidx;
        logic [63:0]           ap;
    } t_entry;

    typedef logic [31:0][7:0] t_tab5;
    typedef logic [63:0][7:0] t_tab6;

    function automatic t_tab5 f_build_tab5();
        t_tab5 tab;
        for (int i = 0; i < 32; i++) begin
            tab[i] = 8'((i * 255) / 31);
        end
        return tab;
    endfunction

    function automatic t_tab6 f_build_tab6();
        t_tab6 tab;
        for (int i = 0; i < 64; i++) begin
            tab[i] = 8'((i * 255) / 63);
        end
        return tab;
    endfunction

    localparam t_tab5 EXPAND5 = f_build_tab5();
    localparam t_tab6 EXPAND6 = f_build_tab6();

    // exact for x <= 765
    function automatic logic [7:0] f_div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

    // exact for x <= 1785
    function automatic logic [7:0] f_div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd2341;
        return p[21:14];
    endfunction

    // exact for x <= 1275
    function automatic logic [7:0] f_div5(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd3277;
        return p[21:14];
    endfunction

endpackage

// ===== hdl/bcdec_if.sv =====
// Valid/ready channel interfaces: compressed block words in, texel words out.
// No dependencies.
`timescale 1ns / 1ps

interface bcdec_blk_if;
    logic        valid;
    logic        ready;
    logic [11:0] block_column;
    logic [11:0] block_row;
    logic [63:0] color_part;
    logic [63:0] alpha_part;

    modport source (output valid, block_column, block_row, color_part, alpha_part,
                    input ready);
    modport sink   (input valid, block_column, block_row, color_part, alpha_part,
                    output ready);
endinterface

interface bcdec_tex_if;
    logic        valid;
    logic        ready;
    logic [13:0] pixel_x;
    logic [13:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha_out;
    logic        inside_res;
    logic        last;

    modport source (output valid, pixel_x, pixel_y, red, green, blue, alpha_out,
                    inside_res, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, red, green, blue, alpha_out,
                    inside_res, last, output ready);
endinterface

// ===== hdl/bcdec_front.sv =====
// Front end: accepts block words, expands endpoints and builds both palettes.
// Two pipeline stages; pushes finished palettes into the queue. Uses bcdec_pkg.
`timescale 1ns / 1ps

module bcdec_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcdec_pkg::t_fmt   i_fmt,
    bcdec_blk_if.sink         i_blk,
    output logic              o_push,
    output bcdec_pkg::t_entry o_entry,
    input  logic              i_push_ready
);
    import bcdec_pkg::*;

    logic                 r_s1_valid;
    logic [11:0]          r_s1_bx, r_s1_by;
    logic [31:0]          r_s1_cidx;
    logic [63:0]          r_s1_ap;
    t_fmt                 r_s1_fmt;
    logic                 r_s1_four;
    logic [2:0][7:0]      r_s1_e0, r_s1_e1;

    logic                 r_s2_valid;
    logic [11:0]          r_s2_bx, r_s2_by;
    logic [31:0]          r_s2_cidx;
    logic [63:0]          r_s2_ap;
    t_fmt                 r_s2_fmt;
    logic                 r_s2_three;
    logic [2:0][7:0]      r_s2_e0, r_s2_e1;
    logic [2:0][9:0]      r_s2_s2, r_s2_s3, r_s2_sh;
    logic                 r_s2_agt;
    logic [5:0][10:0]     r_s2_as7;
    logic [3:0][10:0]     r_s2_as5;

    logic                 s1_ready, s2_ready;
    logic [15:0]          c0, c1;
    t_fmt                 fmt_n;
    logic [7:0]           a0, a1;

    assign s2_ready    = !r_s2_valid || i_push_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_blk.ready = s1_ready;
    assign o_push      = r_s2_valid;

    assign c0 = i_blk.color_part[15:0];
    assign c1 = i_blk.color_part[31:16];
    assign a0 = r_s1_ap[7:0];
    assign a1 = r_s1_ap[15:8];

    always_comb begin
        case (i_fmt)
            FMT_BC2: fmt_n = FMT_BC2;
            FMT_BC3: fmt_n = FMT_BC3;
            default: fmt_n = FMT_BC1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_blk.valid;
        end
        if (s1_ready && i_blk.valid) begin
            r_s1_bx    <= i_blk.block_column;
            r_s1_by    <= i_blk.block_row;
            r_s1_cidx  <= i_blk.color_part[63:32];
            r_s1_ap    <= i_blk.alpha_part;
            r_s1_fmt   <= fmt_n;
            r_s1_four  <= (c0 > c1) || (fmt_n != FMT_BC1);
            r_s1_e0[0] <= EXPAND5[c0[15:11]];
            r_s1_e0[1] <= EXPAND6[c0[10:5]];
            r_s1_e0[2] <= EXPAND5[c0[4:0]];
            r_s1_e1[0] <= EXPAND5[c1[15:11]];
            r_s1_e1[1] <= EXPAND6[c1[10:5]];
            r_s1_e1[2] <= EXPAND5[c1[4:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_bx    <= r_s1_bx;
            r_s2_by    <= r_s1_by;
            r_s2_cidx  <= r_s1_cidx;
            r_s2_ap    <= r_s1_ap;
            r_s2_fmt   <= r_s1_fmt;
            r_s2_three <= !r_s1_four;
            r_s2_e0    <= r_s1_e0;
            r_s2_e1    <= r_s1_e1;
            r_s2_agt   <= a0 > a1;
            for (int k = 0; k < 3; k++) begin
                r_s2_s2[k] <= {1'b0, r_s1_e0[k], 1'b0} + {2'b0, r_s1_e1[k]};
                r_s2_s3[k] <= {2'b0, r_s1_e0[k]} + {1'b0, r_s1_e1[k], 1'b0};
                r_s2_sh[k] <= {2'b0, r_s1_e0[k]} + {2'b0, r_s1_e1[k]};
            end
            for (int k = 0; k < 6; k++) begin
                r_s2_as7[k] <= 11'(6 - k) * {3'b0, a0} + 11'(k + 1) * {3'b0, a1};
            end
            for (int k = 0; k < 4; k++) begin
                r_s2_as5[k] <= 11'(4 - k) * {3'b0, a0} + 11'(k + 1) * {3'b0, a1};
            end
        end
    end

    always_comb begin
        o_entry.bx         = r_s2_bx;
        o_entry.by         = r_s2_by;
        o_entry.fmt        = r_s2_fmt;
        o_entry.three_mode = r_s2_three;
        o_entry.cidx       = r_s2_cidx;
        o_entry.ap         = r_s2_ap;
        o_entry.cpal[0]    = r_s2_e0;
        o_entry.cpal[1]    = r_s2_e1;
        for (int k = 0; k < 3; k++) begin
            if (r_s2_three) begin
                o_entry.cpal[2][k] = r_s2_sh[k][8:1];
                o_entry.cpal[3][k] = 8'd0;
            end else begin
                o_entry.cpal[2][k] = f_div3(r_s2_s2[k]);
                o_entry.cpal[3][k] = f_div3(r_s2_s3[k]);
            end
        end
        o_entry.apal[0] = r_s2_ap[7:0];
        o_entry.apal[1] = r_s2_ap[15:8];
        if (r_s2_agt) begin
            for (int k = 0; k < 6; k++) begin
                o_entry.apal[k + 2] = f_div7(r_s2_as7[k]);
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                o_entry.apal[k + 2] = f_div5(r_s2_as5[k]);
            end
            o_entry.apal[6] = 8'd0;
            o_entry.apal[7] = 8'd255;
        end
    end

endmodule

// ===== hdl/bcdec_queue.sv =====
// Short queue of decoded palettes between the front and back ends.
// Depth from QUEUE_DEPTH in bcdec_pkg.
`timescale 1ns / 1ps

module bcdec_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bcdec_pkg::t_entry i_entry,
    output logic              o_push_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output bcdec_pkg::t_entry o_entry
);
    import bcdec_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_push_ready = r_count < CNT_W'(QUEUE_DEPTH);
    assign o_valid      = r_count != '0;
    assign o_entry      = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= f_next(r_wr);
            end
            if (do_pop) begin
                r_rd <= f_next(r_rd);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(QUEUE_DEPTH)) && !do_pop |=> r_count == CNT_W'(QUEUE_DEPTH))
        else $error("full queue changed without a pop");

endmodule

// ===== hdl/bcdec_back.sv =====
// Back end: walks each queued block's sixteen texels, one a cycle unless
// stalled, into a registered output word. Uses bcdec_pkg, bcdec_tex_if.
`timescale 1ns / 1ps

module bcdec_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcdec_pkg::t_cfg   i_cfg,
    input  logic              i_q_valid,
    input  bcdec_pkg::t_entry i_q_entry,
    output logic              o_pop,
    bcdec_tex_if.source       o_tex
);
    import bcdec_pkg::*;

    t_entry              r_cur;
    logic                r_busy;
    logic [3:0]          r_t;
    logic                r_o_valid;
    logic [13:0]         r_x, r_y;
    logic [7:0]          r_red, r_green, r_blue, r_alpha;
    logic                r_inside, r_last;

    logic                adv, final_texel;
    logic [1:0]          ci;
    logic [3:0]          nib;
    logic [5:0]          aix_pos;
    logic [2:0]          aix;
    logic [7:0]          alpha;
    logic [13:0]         x, y;
    logic [SIDE_W-1:0]   w_eff, h_eff;

    assign adv         = r_busy && (!r_o_valid || o_tex.ready);
    assign final_texel = r_t == 4'(TEXELS - 1);
    assign o_pop       = i_q_valid && (!r_busy || (adv && final_texel));

    assign ci      = r_cur.cidx[{r_t, 1'b0} +: 2];
    assign nib     = r_cur.ap[{r_t, 2'b00} +: 4];
    assign aix_pos = 6'd16 + 6'(r_t) * 6'd3;
    assign aix     = r_cur.ap[aix_pos +: 3];
    assign x       = {r_cur.bx, r_t[1:0]};
    assign y       = {r_cur.by, r_t[3:2]};
    assign w_eff   = (i_cfg.width > SIDE_W'(MAX_IMAGE_SIDE)) ? SIDE_W'(MAX_IMAGE_SIDE)
                                                           : i_cfg.width;
    assign h_eff   = (i_cfg.height > SIDE_W'(MAX_IMAGE_SIDE)) ? SIDE_W'(MAX_IMAGE_SIDE)
                                                            : i_cfg.height;

    always_comb begin
        case (r_cur.fmt)
            FMT_BC2: alpha = {nib, nib};
            FMT_BC3: alpha = r_cur.apal[aix];
            default: alpha = (r_cur.three_mode && ci == 2'd3) ? 8'd0 : 8'd255;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_t       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (adv && final_texel) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_t <= r_t + 1'b1;
            end
            if (adv) begin
                r_o_valid <= 1'b1;
            end else if (o_tex.ready) begin
                r_o_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_cur <= i_q_entry;
        end
        if (adv) begin
            r_x      <= x;
            r_y      <= y;
            r_red    <= r_cur.cpal[ci][0];
            r_green  <= r_cur.cpal[ci][1];
            r_blue   <= r_cur.cpal[ci][2];
            r_alpha  <= alpha;
            r_inside <= (SIDE_W'(x) < w_eff) && (SIDE_W'(y) < h_eff);
            r_last   <= final_texel;
        end
    end

    assign o_tex.valid      = r_o_valid;
    assign o_tex.pixel_x    = r_x;
    assign o_tex.pixel_y    = r_y;
    assign o_tex.red        = r_red;
    assign o_tex.green      = r_green;
    assign o_tex.blue       = r_blue;
    assign o_tex.alpha_out  = r_alpha;
    assign o_tex.inside_res = r_inside;
    assign o_tex.last       = r_last;

    a_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_t == '0)
        else $error("texel counter advanced while idle");

    a_wrap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && final_texel |=> r_t == '0 && r_o_valid && r_last)
        else $error("block end not marked");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && r_busy |-> adv && final_texel)
        else $error("entry replaced mid block");

endmodule

// ===== hdl/bc1_bc2_bc3_block_decoder_top.sv =====
// Top level of the BC1/BC2/BC3 block decoder: configuration registers,
// front end, palette queue and texel back end. Uses bcdec_pkg and bcdec_if.
//
//  channel  dir  word                                   accepted when
//  i_blk    in   block column/row, colour and alpha     valid && ready
//  o_tex    out  one texel with coordinates and flags   valid && ready
//  i_cfg_*  in   register index and data                i_cfg_we high
//
// The back end emits one texel a cycle while the texel channel is not stalled.
// A block passes both front stages, the queue and r_cur before its first texel word.
// Blocks are taken every cycle while the two-entry queue and the front stages have room.
// Synchronous active-low reset clears control state and the registers to
// BC1, width 16384, height 16384.
`timescale 1ns / 1ps

module bc1_bc2_bc3_block_decoder_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bcdec_blk_if.sink                 i_blk,
    bcdec_tex_if.source               o_tex,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [bcdec_pkg::SIDE_W-1:0] i_cfg_data
);
    import bcdec_pkg::*;

    t_cfg   r_cfg;
    logic   push, push_ready, q_valid, pop;
    t_entry push_entry, q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt    <= FMT_BC1;
            r_cfg.width  <= SIDE_W'(MAX_IMAGE_SIDE);
            r_cfg.height <= SIDE_W'(MAX_IMAGE_SIDE);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FORMAT: begin
                    case (i_cfg_data[1:0])
                        FMT_BC2: r_cfg.fmt <= FMT_BC2;
                        FMT_BC3: r_cfg.fmt <= FMT_BC3;
                        default: r_cfg.fmt <= FMT_BC1;
                    endcase
                end
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    bcdec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fmt        (r_cfg.fmt),
        .i_blk        (i_blk),
        .o_push       (push),
        .o_entry      (push_entry),
        .i_push_ready (push_ready)
    );

    bcdec_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (push_entry),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_valid      (q_valid),
        .o_entry      (q_entry)
    );

    bcdec_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_tex     (o_tex)
    );

endmodule

// ===== test/bcdec_texel_checker.sv =====
// Texel checker for the BC1/BC2/BC3 block decoder: decodes every block word taken
// on the input channel and compares each texel word leaving the block in order.
// Depends on bcdec_pkg and the channel interfaces of bcdec_if.
`timescale 1ns / 1ps

module bcdec_texel_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bcdec_blk_if                         i_blk,
    bcdec_tex_if                         i_tex,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [bcdec_pkg::SIDE_W-1:0] i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    import bcdec_pkg::*;

    typedef struct packed {
        logic [13:0] pixel_x;
        logic [13:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha_out;
        logic        inside_res;
        logic        last;
    } t_texel;

    t_texel            expected_texels[$];
    t_texel            want;
    logic [1:0]        cfg_fmt;
    logic [SIDE_W-1:0] cfg_width;
    logic [SIDE_W-1:0] cfg_height;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("texel (%0d,%0d) %s: got %0h, expected %0h",
                                      want.pixel_x, want.pixel_y, name, got, exp_val));
        end
    endtask

    function automatic void decode_block(input logic [11:0] bx, input logic [11:0] by,
                                         input logic [63:0] cp, input logic [63:0] ap);
        int unsigned pal[4][4];
        int unsigned apal[8];
        int unsigned c0, c1, a0, a1, w, h, x, y, ci, a;
        logic [1:0]  fmt;
        t_texel      tx;

        fmt = (cfg_fmt == FMT_BC2 || cfg_fmt == FMT_BC3) ? cfg_fmt : FMT_BC1;
        w   = (cfg_width > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : cfg_width;
        h   = (cfg_height > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : cfg_height;
        c0  = cp[15:0];
        c1  = cp[31:16];

        pal[0][0] = cp[15:11] * 255 / 31;
        pal[0][1] = cp[10:5] * 255 / 63;
        pal[0][2] = cp[4:0] * 255 / 31;
        pal[1][0] = cp[31:27] * 255 / 31;
        pal[1][1] = cp[26:21] * 255 / 63;
        pal[1][2] = cp[20:16] * 255 / 31;
        pal[0][3] = 255;
        pal[1][3] = 255;
        pal[2][3] = 255;
        if (c0 > c1 || fmt != FMT_BC1) begin
            for (int k = 0; k < 3; k++) begin
                pal[2][k] = (2 * pal[0][k] + pal[1][k]) / 3;
                pal[3][k] = (pal[0][k] + 2 * pal[1][k]) / 3;
            end
            pal[3][3] = 255;
        end else begin
            for (int k = 0; k < 3; k++) begin
                pal[2][k] = (pal[0][k] + pal[1][k]) / 2;
                pal[3][k] = 0;
            end
            pal[3][3] = 0;
        end

        a0      = ap[7:0];
        a1      = ap[15:8];
        apal[0] = a0;
        apal[1] = a1;
        if (a0 > a1) begin
            for (int k = 1; k < 7; k++) begin
                apal[k + 1] = ((7 - k) * a0 + k * a1) / 7;
            end
        end else begin
            for (int k = 1; k < 5; k++) begin
                apal[k + 1] = ((5 - k) * a0 + k * a1) / 5;
            end
            apal[6] = 0;
            apal[7] = 255;
        end

        for (int t = 0; t < TEXELS; t++) begin
            x  = bx * 4 + t % 4;
            y  = by * 4 + t / 4;
            ci = cp[32 + 8 * (t / 4) + 2 * (t % 4) +: 2];
            case (fmt)
                FMT_BC2: a = ap[4 * t +: 4] * 17;
                FMT_BC3: a = apal[ap[16 + 3 * t +: 3]];
                default: a = pal[ci][3];
            endcase
            tx.pixel_x    = 14'(x);
            tx.pixel_y    = 14'(y);
            tx.red        = 8'(pal[ci][0]);
            tx.green      = 8'(pal[ci][1]);
            tx.blue       = 8'(pal[ci][2]);
            tx.alpha_out  = 8'(a);
            tx.inside_res = (x < w) && (y < h);
            tx.last       = (t == TEXELS - 1);
            expected_texels.push_back(tx);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_texels.delete();
            cfg_fmt    = FMT_BC1;
            cfg_width  = SIDE_W'(MAX_IMAGE_SIDE);
            cfg_height = SIDE_W'(MAX_IMAGE_SIDE);
        end else begin
            if (i_tex.valid && i_tex.ready) begin
                if (expected_texels.size() == 0) begin
                    report_mismatch($sformatf("texel word (%0d,%0d) with none expected",
                                              i_tex.pixel_x, i_tex.pixel_y));
                end else begin
                    want = expected_texels.pop_front();
                    check_field("pixel_x", i_tex.pixel_x, want.pixel_x);
                    check_field("pixel_y", i_tex.pixel_y, want.pixel_y);
                    check_field("red", i_tex.red, want.red);
                    check_field("green", i_tex.green, want.green);
                    check_field("blue", i_tex.blue, want.blue);
                    check_field("alpha_out", i_tex.alpha_out, want.alpha_out);
                    check_field("inside_res", i_tex.inside_res, want.inside_res);
                    check_field("last", i_tex.last, want.last);
                end
            end
            if (i_blk.valid && i_blk.ready) begin
                decode_block(i_blk.block_column, i_blk.block_row,
                             i_blk.color_part, i_blk.alpha_part);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FORMAT: cfg_fmt    = i_cfg_data[1:0];
                    CFG_WIDTH:  cfg_width  = i_cfg_data;
                    CFG_HEIGHT: cfg_height = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = expected_texels.size();
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the BC1/BC2/BC3 block decoder: clock, reset, register writes,
// block words in and texel back-pressure out; the texel checker does the comparing.
// Depends on bcdec_pkg, bcdec_if, the decoder top and bcdec_texel_checker.
`timescale 1ns / 1ps

module tb;
    import bcdec_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [1:0] FMT_SPARE  = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [SIDE_W-1:0] cfg_data;
    bit                gaps_on;
    bit                stalls_on;
    int                fail_count;
    int                pending;

    bcdec_blk_if blk_if ();
    bcdec_tex_if tex_if ();

    bc1_bc2_bc3_block_decoder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_blk       (blk_if),
        .o_tex       (tex_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bcdec_texel_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_blk        (blk_if),
        .i_tex        (tex_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 clk = ~clk;

    always @(negedge clk) begin
        tex_if.ready <= !stalls_on || ($urandom_range(0, 99) >= 35);
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_block(input logic [11:0] bx, input logic [11:0] by,
                              input logic [63:0] cp, input logic [63:0] ap);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 35) begin
            blk_if.valid <= 1'b0;
            @(negedge clk);
        end
        blk_if.valid        <= 1'b1;
        blk_if.block_column <= bx;
        blk_if.block_row    <= by;
        blk_if.color_part   <= cp;
        blk_if.alpha_part   <= ap;
        @(posedge clk);
        while (!blk_if.ready) @(posedge clk);
    endtask

    task automatic drain_texels();
        @(negedge clk);
        blk_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [SIDE_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_regs(input logic [1:0] fmt, input logic [SIDE_W-1:0] w,
                            input logic [SIDE_W-1:0] h);
        drain_texels();
        write_reg(CFG_FORMAT, SIDE_W'(fmt));
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    task automatic random_block();
        logic [11:0] bx, by;
        logic [63:0] cp, ap;
        logic [15:0] ca, cb;
        logic [7:0]  aa, ab;
        int          mode;

        bx = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 7)) : 12'($urandom);
        by = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 7)) : 12'($urandom);
        cp = {$urandom, $urandom};
        ap = {$urandom, $urandom};

        ca   = cp[15:0];
        cb   = cp[31:16];
        mode = $urandom_range(0, 3);
        if (ca == cb) cb = ca ^ 16'd1;
        case (mode)
            1: cp[31:0]  = (ca > cb) ? {cb, ca} : {ca, cb};
            2: cp[31:0]  = (ca > cb) ? {ca, cb} : {cb, ca};
            3: cp[31:16] = cp[15:0];
            default: ;
        endcase

        aa   = ap[7:0];
        ab   = ap[15:8];
        mode = $urandom_range(0, 3);
        if (aa == ab) ab = aa ^ 8'd1;
        case (mode)
            1: ap[15:0] = (aa > ab) ? {ab, aa} : {aa, ab};
            2: ap[15:0] = (aa > ab) ? {aa, ab} : {ab, aa};
            3: ap[15:8] = ap[7:0];
            default: ;
        endcase

        send_block(bx, by, cp, ap);
    endtask

    task automatic random_phase(input logic [1:0] fmt, input logic [SIDE_W-1:0] w,
                                input logic [SIDE_W-1:0] h, input int count,
                                input bit idle, input bit hold_mid);
        set_regs(fmt, w, h);
        gaps_on   <= idle;
        stalls_on <= idle;
        for (int i = 0; i < count; i++) begin
            random_block();
            if (hold_mid && i == count / 2) drain_texels();
        end
    endtask

    initial begin
        logic [47:0] seq_idx;

        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_FORMAT;
        cfg_data            = '0;
        blk_if.valid        = 1'b0;
        blk_if.block_column = '0;
        blk_if.block_row    = '0;
        blk_if.color_part   = '0;
        blk_if.alpha_part   = '0;
        tex_if.ready        = 1'b0;
        gaps_on             = 1'b1;
        stalls_on           = 1'b1;
        for (int t = 0; t < TEXELS; t++) begin
            seq_idx[3 * t +: 3] = 3'(t % 8);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values: BC1, full-size image
        send_block(12'd0, 12'd0, 64'd0, 64'd0);
        send_block(12'd4095, 12'd4095, '1, '1);
        send_block(12'd1, 12'd2, {32'hE4E4_E4E4, 16'h0000, 16'hFFFF}, 64'd0);
        send_block(12'd3, 12'd0, {32'h1B1B_1B1B, 16'hF800, 16'h07E0}, '1);

        // spare format code decodes as BC1; small image clips texels
        set_regs(FMT_SPARE, 15'd6, 15'd5);
        send_block(12'd1, 12'd1, {32'hE4E4_E4E4, 16'h001F, 16'h07E0},
                   {$urandom, $urandom});
        send_block(12'd0, 12'd0, {32'h1B1B_1B1B, 16'h8410, 16'h8410}, 64'd0);
        send_block(12'd4095, 12'd0, {$urandom, $urandom}, {$urandom, $urandom});

        // zero width leaves every texel outside
        set_regs(FMT_BC2, 15'd0, 15'd16384);
        send_block(12'd0, 12'd0, {32'hE4E4_E4E4, 16'hFFFF, 16'h0000}, '1);
        send_block(12'd5, 12'd5, {$urandom, $urandom}, 64'd0);
        send_block(12'd7, 12'd9, {$urandom, $urandom}, 64'h0123_4567_89AB_CDEF);

        // oversize registers clamp to the largest image side
        set_regs(FMT_BC3, 15'h7FFF, 15'h7FFF);
        send_block(12'd4095, 12'd4095, {32'hE4E4_E4E4, 16'h1234, 16'hABCD},
                   {seq_idx, 8'h00, 8'hFF});
        send_block(12'd4095, 12'd4094, {$urandom, $urandom}, {seq_idx, 8'hC8, 8'h14});
        send_block(12'd4094, 12'd4095, {$urandom, $urandom}, {seq_idx, 8'h80, 8'h80});
        send_block(12'd0, 12'd4095, {$urandom, $urandom}, '1);

        // write to an unused index must leave the registers alone
        drain_texels();
        write_reg(CFG_UNUSED, 15'd0);
        send_block(12'd2, 12'd2, {$urandom, $urandom}, {seq_idx, 8'h00, 8'hFF});

        random_phase(FMT_BC1, 15'd16384, 15'd16384, 50, 1'b0, 1'b0);
        random_phase(FMT_BC2, 15'($urandom_range(1, MAX_IMAGE_SIDE)),
                     15'($urandom_range(1, MAX_IMAGE_SIDE)), 45, 1'b1, 1'b1);
        random_phase(FMT_BC3, 15'd1, 15'd1, 40, 1'b1, 1'b0);
        random_phase(FMT_SPARE, 15'h7FFF, 15'd0, 35, 1'b1, 1'b0);
        random_phase(FMT_BC3, 15'($urandom), 15'($urandom), 50, 1'b1, 1'b1);
        random_phase(FMT_BC1, 15'd16384, 15'd1, 30, 1'b1, 1'b0);
        random_phase(FMT_BC2, 15'($urandom_range(1, MAX_IMAGE_SIDE)),
                     15'h7FFF, 30, 1'b1, 1'b0);

        drain_texels();
        repeat (16) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
